// ===== src/series_logarithm_unit_macros.svh =====
// Assertion macros for the series logarithm unit.
// Used by src/series_logarithm_unit.sv; needs nothing else.
`ifndef SERIES_LOGARITHM_UNIT_MACROS_SVH
`define SERIES_LOGARITHM_UNIT_MACROS_SVH

// same-cycle implication
`define SLU_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define SLU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== src/slu_pkg.sv =====
// Package of the series logarithm unit: sequencer states, codes and constants.
// Used by src/series_logarithm_unit.sv.
package slu_pkg;

   typedef enum logic [3:0] {
      ST_IDLE, ST_NORM, ST_SDIV, ST_SMUL, ST_LNFIN,
      ST_KMUL1, ST_KMUL2, ST_QDIV, ST_FINAL, ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      STAT_VALID   = 2'd0,
      STAT_INVALID = 2'd1,
      STAT_SAT     = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      MODE_LN = 2'd0, MODE_LOG2 = 2'd1, MODE_LOG10 = 2'd2, MODE_BASE = 2'd3
   } mode_type;

   localparam logic CFG_MAX_TERMS = 1'b0;
   localparam logic CFG_STOP_THR  = 1'b1;

   localparam logic [31:0] LN2_Q32      = 32'd2977044472;
   localparam logic [32:0] INV_LN2_Q32  = 33'd6196328019;
   localparam logic [32:0] INV_LN10_Q32 = 33'd1865280597;

endpackage

// ===== src/series_logarithm_unit.sv =====
// Each logarithm runs the series once (twice in base mode, followed by the quotient
// division); invalid items go straight to the finish state. One item at a time.
// The rate is set by the shared restoring divider (one quotient bit a cycle) used for
// every series term and for the base-mode quotient.
// Reset (synchronous, active high) clears the sequencer and sets max_terms to 100 and
// stop_threshold to 1.
module series_logarithm_unit #(
   parameter int IN_FRAC_BITS  = 16,
   parameter int OUT_FRAC_BITS = 26,
   parameter int TERM_LIMIT    = 100
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic [31:0] req_value,
   input  logic [31:0] req_base,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic signed [31:0] rsp_result,
   output logic [1:0]  rsp_status,
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [7:0]  csr_data
);
   import slu_pkg::*;
`include "series_logarithm_unit_macros.svh"

   localparam int NW = $clog2(TERM_LIMIT + 1);
   localparam int MW = 44;
   localparam int DW = 40;
   localparam int QW = 72;
   localparam int LW = 46;

   state_type state_ff, state_in;
   logic [6:0] max_terms_ff, max_terms_in;
   logic [7:0] thr_ff, thr_in;
   logic [1:0] mode_ff, mode_in;
   logic [31:0] base_ff, base_in;
   logic second_ff, second_in;
   logic [31:0] sh_ff, sh_in;
   logic [4:0] p_ff, p_in;
   logic signed [7:0] e_ff, e_in;
   logic [31:0] a_ff, a_in, pw_ff, pw_in;
   logic [39:0] sum_ff, sum_in;
   logic [NW-1:0] n_ff, n_in, nt;
   logic [QW-1:0] dq_ff, dq_in;
   logic [DW:0] dr_ff, dr_in;
   logic [DW-1:0] dd_ff, dd_in;
   logic [6:0] step_ff, step_in;
   logic signed [LW-1:0] la_ff, la_in;
   logic [MW-1:0] m_ff, m_in;
   logic neg_ff, neg_in;
   logic [63:0] kp_ff, kp_in;
   logic signed [31:0] res_ff, res_in;
   logic [1:0] stat_ff, stat_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] rsp_result_ff, rsp_result_in;
   logic [1:0] rsp_status_ff, rsp_status_in;

   logic req_take, req_bad, out_free, pow2, ge, stop_now;
   logic [DW:0] rem_sh;
   logic [DW+1:0] diff;
   logic [31:0] t_val;
   logic [63:0] pw_prod;
   logic signed [LW-1:0] lnv;
   logic [LW-1:0] lnv_mag, la_mag;
   logic [32:0] kconst;
   logic [MW:0] mo;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign req_bad   = (req_value == 32'd0) || ((req_mode == MODE_BASE) &&
                      ((req_base == 32'd0) || (req_base == (32'd1 << IN_FRAC_BITS))));
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_result = rsp_result_ff;
   assign rsp_status = rsp_status_ff;

   always_comb begin
      if (max_terms_ff == 7'd0) nt = NW'(1);
      else if (32'(max_terms_ff) > TERM_LIMIT) nt = NW'(TERM_LIMIT);
      else nt = NW'(max_terms_ff);
   end

   assign rem_sh   = {dr_ff[DW-1:0], dq_ff[QW-1]};
   assign diff     = {1'b0, rem_sh} - {2'b0, dd_ff};
   assign ge       = !diff[DW+1];
   assign t_val    = dq_ff[31:0];
   assign stop_now = (n_ff != NW'(1)) && (t_val < {24'd0, thr_ff});
   assign pw_prod  = pw_ff * a_ff;
   assign pow2     = (sh_ff == 32'h8000_0000);
   assign lnv      = (LW'(e_ff) * $signed({14'd0, LN2_Q32})) - $signed({6'd0, sum_ff});
   assign lnv_mag  = lnv[LW-1] ? LW'(-lnv) : LW'(lnv);
   assign la_mag   = la_ff[LW-1] ? LW'(-la_ff) : LW'(la_ff);
   assign kconst   = (mode_ff == MODE_LOG2) ? INV_LN2_Q32 : INV_LN10_Q32;
   assign mo       = (mode_ff == MODE_BASE) ? {1'b0, m_ff}
                     : ({1'b0, m_ff} >> (32 - OUT_FRAC_BITS));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_take) state_in = req_bad ? ST_FINISH : ST_NORM;
         ST_NORM:   if (sh_ff[31]) state_in = ST_SDIV;
         ST_SDIV:   if (step_ff == 7'd0) state_in = stop_now ? ST_LNFIN : ST_SMUL;
         ST_SMUL:   state_in = (n_ff == nt) ? ST_LNFIN : ST_SDIV;
         ST_LNFIN: begin
            if (!second_ff) begin
               if (mode_ff == MODE_BASE) state_in = ST_NORM;
               else if (mode_ff == MODE_LN) state_in = ST_FINAL;
               else state_in = ST_KMUL1;
            end else begin
               state_in = (lnv == '0) ? ST_FINISH : ST_QDIV;
            end
         end
         ST_KMUL1:  state_in = ST_KMUL2;
         ST_KMUL2:  state_in = ST_FINAL;
         ST_QDIV:   if (step_ff == 7'd0) state_in = ST_FINAL;
         ST_FINAL:  state_in = ST_FINISH;
         ST_FINISH: if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      max_terms_in = max_terms_ff;
      thr_in = thr_ff;
      mode_in = mode_ff; base_in = base_ff; second_in = second_ff;
      sh_in = sh_ff; p_in = p_ff; e_in = e_ff; a_in = a_ff; pw_in = pw_ff;
      sum_in = sum_ff; n_in = n_ff;
      dq_in = dq_ff; dr_in = dr_ff; dd_in = dd_ff; step_in = step_ff;
      la_in = la_ff; m_in = m_ff; neg_in = neg_ff; kp_in = kp_ff;
      res_in = res_ff; stat_in = stat_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_result_in = rsp_result_ff; rsp_status_in = rsp_status_ff;

      if (csr_wr_en) begin
         unique case (csr_index)
            CFG_MAX_TERMS: max_terms_in = csr_data[6:0];
            CFG_STOP_THR:  thr_in = csr_data;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               mode_in = req_mode; base_in = req_base;
               sh_in = req_value; p_in = 5'd31; second_in = 1'b0;
               res_in = '0; stat_in = STAT_INVALID;
            end
         end
         ST_NORM: begin
            if (sh_ff[31]) begin
               e_in = 8'(p_ff) + (pow2 ? 8'sd0 : 8'sd1) - 8'(IN_FRAC_BITS);
               a_in = pow2 ? 32'd0 : 32'(33'h1_0000_0000 - {1'b0, sh_ff});
               pw_in = pow2 ? 32'd0 : 32'(33'h1_0000_0000 - {1'b0, sh_ff});
               dq_in = {(pow2 ? 32'd0 : 32'(33'h1_0000_0000 - {1'b0, sh_ff})), 40'd0};
               sum_in = '0; n_in = NW'(1);
               dr_in = '0; dd_in = DW'(1); step_in = 7'd32;
            end else begin
               sh_in = {sh_ff[30:0], 1'b0};
               p_in = p_ff - 5'd1;
            end
         end
         ST_SDIV: begin
            if (step_ff != 7'd0) begin
               dr_in = ge ? diff[DW:0] : rem_sh;
               dq_in = {dq_ff[QW-2:0], ge};
               step_in = step_ff - 7'd1;
            end else if (!stop_now) begin
               sum_in = sum_ff + {8'd0, t_val};
            end
         end
         ST_SMUL: begin
            pw_in = pw_prod[63:32];
            n_in = n_ff + NW'(1);
            dq_in = {pw_prod[63:32], 40'd0};
            dr_in = '0; dd_in = DW'(n_ff + NW'(1)); step_in = 7'd32;
         end
         ST_LNFIN: begin
            if (!second_ff) begin
               la_in = lnv;
               m_in = MW'(lnv_mag);
               neg_in = lnv[LW-1];
               sh_in = base_ff; p_in = 5'd31; second_in = 1'b1;
            end else if (lnv != '0) begin
               neg_in = la_ff[LW-1] ^ lnv[LW-1];
               dq_in = QW'(la_mag) << OUT_FRAC_BITS;
               dr_in = '0; dd_in = DW'(lnv_mag); step_in = 7'(QW);
            end
         end
         ST_KMUL1: kp_in = m_ff[31:0] * kconst[31:0];
         ST_KMUL2: m_in = (MW'(m_ff[MW-1:32]) * MW'(kconst))
                        + (kconst[32] ? {12'd0, m_ff[31:0]} : MW'(0))
                        + {12'd0, kp_ff[63:32]};
         ST_QDIV: begin
            if (step_ff != 7'd0) begin
               dr_in = ge ? diff[DW:0] : rem_sh;
               dq_in = {dq_ff[QW-2:0], ge};
               step_in = step_ff - 7'd1;
            end else begin
               m_in = (dq_ff[QW-1:32] != '0) ? MW'(64'h1_0000_0000) : MW'(dq_ff);
            end
         end
         ST_FINAL: begin
            stat_in = STAT_VALID;
            if (mo == '0) begin
               res_in = '0;
            end else if (neg_ff) begin
               if (mo > (MW+1)'(64'h8000_0000)) begin
                  res_in = 32'sh8000_0000; stat_in = STAT_SAT;
               end else begin
                  res_in = 32'(-mo);
               end
            end else begin
               if (mo > (MW+1)'(64'h7FFF_FFFF)) begin
                  res_in = 32'sh7FFF_FFFF; stat_in = STAT_SAT;
               end else begin
                  res_in = 32'(mo);
               end
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_result_in = res_ff;
               rsp_status_in = stat_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         max_terms_ff <= 7'd100;
         thr_ff <= 8'd1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         max_terms_ff <= max_terms_in;
         thr_ff <= thr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff <= mode_in; base_ff <= base_in; second_ff <= second_in;
      sh_ff <= sh_in; p_ff <= p_in; e_ff <= e_in; a_ff <= a_in; pw_ff <= pw_in;
      sum_ff <= sum_in; n_ff <= n_in;
      dq_ff <= dq_in; dr_ff <= dr_in; dd_ff <= dd_in; step_ff <= step_in;
      la_ff <= la_in; m_ff <= m_in; neg_ff <= neg_in; kp_ff <= kp_in;
      res_ff <= res_in; stat_ff <= stat_in;
      rsp_result_ff <= rsp_result_in; rsp_status_ff <= rsp_status_in;
   end

   `SLU_ASSERT_NEXT(a_take_busy, clock, reset, req_take, state_ff != ST_IDLE)
   `SLU_ASSERT_SAME(a_term_nonzero, clock, reset, state_ff == ST_SDIV,
      (n_ff != '0) && (n_ff <= nt))
   `SLU_ASSERT_NEXT(a_finish_out, clock, reset, (state_ff == ST_FINISH) && out_free,
      rsp_valid_ff && (state_ff == ST_IDLE))
   `SLU_ASSERT_SAME(a_invalid_zero, clock, reset,
      rsp_valid_ff && (rsp_status_ff == STAT_INVALID), rsp_result_ff == '0)

endmodule

// ===== tb/sv/series_logarithm_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for series_logarithm_unit: directed and random logarithm items
// under several series settings, with random idling on both channels.
// Depends on slu_pkg and the series_logarithm_unit RTL.
module series_logarithm_unit_tb;
   import slu_pkg::*;

   localparam longint CYCLE_LIMIT = 100000000;

   typedef struct {
      logic signed [31:0] result;
      status_type         status;
   } log_out_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_mode = '0;
   logic [31:0] req_value = '0;
   logic [31:0] req_base = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic signed [31:0] rsp_result;
   logic [1:0]  rsp_status;
   logic        csr_wr_en = 1'b0;
   logic        csr_index = 1'b0;
   logic [7:0]  csr_data = '0;

   log_out_type expected_logs[$];
   logic [6:0]  max_terms_q = 7'd100;
   logic [7:0]  stop_thr_q = 8'd1;
   longint      cycle_count = 0;
   int          hold_off = 0;
   bit          quiet_rsp = 1'b0;
   int          errors = 0;
   int          checked = 0;
   int          mode_count[4] = '{0, 0, 0, 0};
   int          invalid_count = 0;
   int          sat_count = 0;

   series_logarithm_unit uut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d items outstanding", cycle_count,
                  expected_logs.size());
         $display("series_logarithm_unit_tb: FAIL");
         $finish;
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // ln of v, 32 fraction bits, signed
   function automatic longint ln_fixed(logic [31:0] v);
      int p;
      longint e;
      logic [63:0] a, pw, sum, t, nt;
      p = 31;
      while (p > 0 && !v[p]) p--;
      if ({32'd0, v} == (64'd1 << p)) begin
         e = p - 16;
         a = 0;
      end else begin
         e = p + 1 - 16;
         a = ((64'd1 << (p + 1)) - {32'd0, v}) << (31 - p);
      end
      nt = (max_terms_q == 0) ? 1 : (max_terms_q > 100) ? 100 : max_terms_q;
      pw = a;
      sum = 0;
      for (longint n = 1; n <= nt; n++) begin
         t = pw / n;
         if (n > 1 && t < stop_thr_q) break;
         sum += t;
         pw = (pw * a) >> 32;
      end
      return e * longint'(LN2_Q32) - longint'(sum);
   endfunction

   function automatic log_out_type predict_log(logic [1:0] mode, logic [31:0] value,
                                               logic [31:0] base);
      log_out_type o;
      longint la, lb;
      bit neg;
      logic [63:0] m, d, q;
      logic [127:0] wide;
      o.result = 0;
      o.status = STAT_INVALID;
      if (value == 0) return o;
      if (mode == MODE_BASE && (base == 0 || base == 32'h0001_0000)) return o;
      la = ln_fixed(value);
      neg = la < 0;
      m = neg ? -la : la;
      if (mode == MODE_BASE) begin
         lb = ln_fixed(base);
         if (lb == 0) return o;
         neg = neg ^ (lb < 0);
         d = (lb < 0) ? -lb : lb;
         q = m / d;
         if ((q >> 6) != 0) m = 64'd1 << 32;
         else begin
            wide = ({64'd0, m} << 26) / {64'd0, d};
            m = wide[63:0];
         end
      end else begin
         if (mode == MODE_LOG2) begin
            wide = {64'd0, m} * {95'd0, INV_LN2_Q32};
            m = wide >> 32;
         end else if (mode == MODE_LOG10) begin
            wide = {64'd0, m} * {95'd0, INV_LN10_Q32};
            m = wide >> 32;
         end
         m = m >> 6;
      end
      if (m == 0) neg = 0;
      o.status = STAT_VALID;
      if (neg) begin
         if (m > 64'h8000_0000) begin
            m = 64'h8000_0000;
            o.status = STAT_SAT;
         end
         o.result = -m[31:0];
      end else begin
         if (m > 64'h7FFF_FFFF) begin
            m = 64'h7FFF_FFFF;
            o.status = STAT_SAT;
         end
         o.result = m[31:0];
      end
      return o;
   endfunction

   task automatic send_log(logic [1:0] mode, logic [31:0] value, logic [31:0] base);
      int gap;
      log_out_type o;
      @(negedge clock);
      req_valid <= 1'b1;
      req_mode  <= mode;
      req_value <= value;
      req_base  <= base;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      o = predict_log(mode, value, base);
      expected_logs.push_back(o);
      mode_count[mode]++;
      if (o.status == STAT_INVALID) invalid_count++;
      if (o.status == STAT_SAT) sat_count++;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // random response-side idling, with quiet stretches and forced hold-offs
   always @(negedge clock) begin
      if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_stall <= 1'b1;
      end else if (quiet_rsp) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(0, 99) < 30);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_logs.size() == 0) begin
            $display("%0t: unexpected item result=%0d status=%0d", $time, rsp_result,
                     rsp_status);
            errors++;
         end else begin
            log_out_type e;
            e = expected_logs.pop_front();
            checked++;
            if (rsp_result !== e.result || rsp_status !== e.status) begin
               $display("%0t: mismatch expected result=%0d status=%0d actual result=%0d status=%0d",
                        $time, e.result, e.status, rsp_result, rsp_status);
               errors++;
            end
         end
      end
   end

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_logs.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_csr(logic index, logic [7:0] data);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      if (index == CFG_MAX_TERMS) max_terms_q = data[6:0];
      else stop_thr_q = data;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic set_series(logic [7:0] terms, logic [7:0] thr);
      drain();
      write_csr(CFG_MAX_TERMS, terms);
      write_csr(CFG_STOP_THR, thr);
   endtask

   function automatic logic [31:0] rand_operand();
      int r;
      int s;
      r = $urandom_range(0, 9);
      s = $urandom_range(0, 31);
      case (r)
         0: return 32'd1 << s;
         1: return (32'd1 << s) + $urandom_range(0, 3);
         2: return (32'd1 << s) - $urandom_range(0, 3);
         3: return $urandom_range(0, 3);
         4: return 32'h0001_0000 + $urandom_range(0, 300) - 150;
         5: return $urandom() >> s;
         default: return $urandom();
      endcase
   endfunction

   task automatic test_directed();
      for (int md = 0; md < 4; md++) begin
         send_log(2'(md), 32'd0, 32'h0002_0000);
         send_log(2'(md), 32'h0001_0000, 32'h0002_0000);
         send_log(2'(md), 32'hFFFF_FFFF, 32'h0000_0001);
         send_log(2'(md), 32'h0000_0001, 32'hFFFF_FFFF);
      end
      send_log(MODE_BASE, 32'h0003_0000, 32'h0000_0000);
      send_log(MODE_BASE, 32'h0003_0000, 32'h0001_0000);
      send_log(MODE_BASE, 32'hFFFF_FFFF, 32'h0001_0001);
      send_log(MODE_BASE, 32'h0000_0001, 32'h0000_FFFF);
      send_log(MODE_LN, 32'h8000_0000, 32'hAAAA_5555);
      send_log(MODE_LOG2, 32'h0000_C000, 32'h5555_AAAA);
      send_log(MODE_LOG10, 32'h0001_8000, 32'h0);
      send_log(MODE_BASE, 32'h0001_0000, 32'h0004_0000);
   endtask

   task automatic test_random(int count);
      for (int i = 0; i < count; i++)
         send_log(2'($urandom_range(0, 3)), rand_operand(), rand_operand());
   endtask

   task automatic test_quiet_random(int count);
      quiet_rsp = 1'b1;
      for (int i = 0; i < count; i++) begin
         @(negedge clock);
         req_valid <= 1'b1;
         req_mode  <= 2'($urandom_range(0, 3));
         req_value <= rand_operand();
         req_base  <= rand_operand();
         @(posedge clock);
         while (req_stall) @(posedge clock);
         expected_logs.push_back(predict_log(req_mode, req_value, req_base));
         mode_count[req_mode]++;
      end
      quiet_rsp = 1'b0;
   endtask

   task automatic test_backpressure();
      hold_off = 3000;
      test_random(20);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(500);
      test_quiet_random(100);
      test_backpressure();
      set_series(8'd1, 8'd0);
      test_random(300);
      set_series(8'd127, 8'd0);
      test_random(60);
      set_series(8'd0, 8'd255);
      test_random(300);
      set_series(8'd20, 8'd30);
      test_random(350);
      set_series(8'd100, 8'd1);
      test_random(200);
      drain();
      $display("checked %0d results: ln %0d, log2 %0d, log10 %0d, base %0d", checked,
               mode_count[0], mode_count[1], mode_count[2], mode_count[3]);
      $display("invalid %0d, saturated %0d, five series settings", invalid_count, sat_count);
      if (errors == 0 && expected_logs.size() == 0)
         $display("series_logarithm_unit_tb: PASS");
      else
         $display("series_logarithm_unit_tb: FAIL");
      $finish;
   end

endmodule
